/* hw/rtl/pcs_pkg.sv */
package pcs_pkg;

  localparam int ExpW         = 5;
  localparam int DataW        = 32;
  localparam int FracBits     = 16;
  localparam int MaxTermsDef  = 32;
  localparam int CoefWidthDef = 32;

  typedef enum logic [2:0] {
    CMD_ASSIGN = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_READ   = 3'd2,
    CMD_EVAL   = 3'd3,
    CMD_NEXT   = 3'd4,
    CMD_PREV   = 3'd5,
    CMD_CLEAR  = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_EV_LOAD,
    S_EV_MUL,
    S_EV_ADD,
    S_SCAN,
    S_DONE
  } state_e;

endpackage

/* hw/rtl/polynomial_coefficient_store.sv */
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | cmd_i, exponent_in_i, value_in_i
// out     | output    | out_valid_o/out_stall_i | coef_out_o, eval_out_o, degree_out_o,
//         |           |                         | term_index_o, term_found_o, saturated_o
//
// One transaction at a time: a sequencer around one RAM (a write port and a read port) and one multiplier.
// Evaluate performs a multiply and an add per term.
// A search reads entries one by one and stops at the first nonzero entry.
// Zeroing the top term adds the same downward scan after the write.
// Clear zeroes all T entries, T = min(MAX_TERMS, 32); reset starts the same clearing pass, in_stall_o high.
// The result register holds on out_stall_i while the next transaction runs; done waits for it.
module polynomial_coefficient_store #(
  parameter int MAX_TERMS  = pcs_pkg::MaxTermsDef,
  parameter int COEF_WIDTH = pcs_pkg::CoefWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  cmd_i,
  input  logic [pcs_pkg::ExpW-1:0]    exponent_in_i,
  input  logic signed [pcs_pkg::DataW-1:0] value_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [pcs_pkg::DataW-1:0] coef_out_o,
  output logic signed [pcs_pkg::DataW-1:0] eval_out_o,
  output logic [pcs_pkg::ExpW-1:0]    degree_out_o,
  output logic [pcs_pkg::ExpW-1:0]    term_index_o,
  output logic                        term_found_o,
  output logic                        saturated_o
);

  localparam int ExpW   = pcs_pkg::ExpW;
  localparam int DataW  = pcs_pkg::DataW;
  localparam int Live   = (MAX_TERMS < (2 ** ExpW)) ? MAX_TERMS : (2 ** ExpW);
  localparam int AW     = $clog2(Live);
  localparam int CoefW  = (COEF_WIDTH > DataW) ? DataW : COEF_WIDTH;
  localparam int PW     = CoefW + DataW;
  localparam int SumW   = (CoefW + 18 > DataW + 2) ? CoefW + 18 : DataW + 2;
  localparam logic [ExpW:0] LiveW = (ExpW + 1)'(Live);
  localparam logic [AW-1:0] LastIdx = AW'(Live - 1);
  localparam logic signed [SumW-1:0] CoefMax = SumW'((65'd1 << (CoefW - 1)) - 65'd1);
  localparam logic signed [SumW-1:0] CoefMin = ~CoefMax;

  function automatic logic [CoefW:0] clip_f(input logic signed [SumW-1:0] v);
    logic [CoefW:0] r;
    if (v > CoefMax) begin
      r = {1'b1, CoefMax[CoefW-1:0]};
    end else if (v < CoefMin) begin
      r = {1'b1, CoefMin[CoefW-1:0]};
    end else begin
      r = {1'b0, v[CoefW-1:0]};
    end
    return r;
  endfunction

  pcs_pkg::state_e state_q, state_d;
  pcs_pkg::cmd_e   cmd_q, cmd_d;
  logic [ExpW-1:0] ex_q, ex_d;
  logic signed [DataW-1:0] x_q, x_d;
  logic [AW-1:0] deg_q, deg_d;
  logic signed [CoefW-1:0] acc_q, acc_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic [AW-1:0] n_q, n_d;
  logic [AW-1:0] scan_q, scan_d;
  logic [AW-1:0] scan_end_q, scan_end_d;
  logic scan_go_q, scan_go_d;
  logic scan_up_q, scan_up_d;
  logic scan_low_q, scan_low_d;
  logic rd_v_q, rd_v_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [AW-1:0] clr_q, clr_d;
  logic clr_item_q, clr_item_d;
  logic signed [CoefW-1:0] res_coef_q, res_coef_d;
  logic [AW-1:0] res_idx_q, res_idx_d;
  logic res_found_q, res_found_d;
  logic res_sat_q, res_sat_d;
  logic out_valid_q, out_valid_d;
  logic signed [DataW-1:0] out_coef_q, out_coef_d;
  logic signed [DataW-1:0] out_eval_q, out_eval_d;
  logic [ExpW-1:0] out_deg_q, out_deg_d;
  logic [ExpW-1:0] out_idx_q, out_idx_d;
  logic out_found_q, out_found_d;
  logic out_sat_q, out_sat_d;

  logic signed [CoefW-1:0] mem [Live];
  logic signed [CoefW-1:0] mem_rd_q;
  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic signed [CoefW-1:0] mem_wd;

  logic [CoefW:0] asg_res, add_res, ev_res;
  logic signed [SumW-1:0] add_sum, ev_sum;
  logic ev_inc;
  logic [ExpW:0] ex_ext, nx_start6, pv_lim6, pv_start6;
  logic in_range, ex_le_deg, ex_gt_deg, ex_eq_deg;
  logic signed [CoefW-1:0] wr_val;
  logic rd_hit;

  assign ev_inc  = prod_q[PW-1] && (prod_q[pcs_pkg::FracBits-1:0] != '0);
  assign ev_sum  = SumW'(prod_q >>> pcs_pkg::FracBits) + SumW'(mem_rd_q) + SumW'(ev_inc);
  assign add_sum = SumW'(mem_rd_q) + SumW'(x_q);
  assign asg_res = clip_f(SumW'(x_q));
  assign add_res = clip_f(add_sum);
  assign ev_res  = clip_f(ev_sum);

  assign ex_ext    = {1'b0, ex_q};
  assign in_range  = ex_ext < LiveW;
  assign ex_le_deg = ex_ext <= (ExpW + 1)'(deg_q);
  assign ex_gt_deg = ex_ext > (ExpW + 1)'(deg_q);
  assign ex_eq_deg = ex_ext == (ExpW + 1)'(deg_q);
  assign wr_val    = (cmd_q == pcs_pkg::CMD_ADD) ? add_res[CoefW-1:0] : asg_res[CoefW-1:0];

  assign nx_start6 = {1'b0, exponent_in_i} + (ExpW + 1)'(1);
  assign pv_lim6   = ({1'b0, exponent_in_i} < LiveW) ? {1'b0, exponent_in_i} : LiveW;
  assign pv_start6 = pv_lim6 - (ExpW + 1)'(1);

  assign rd_hit = rd_v_q && (mem_rd_q != '0);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    ex_d        = ex_q;
    x_d         = x_q;
    deg_d       = deg_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    n_d         = n_q;
    scan_d      = scan_q;
    scan_end_d  = scan_end_q;
    scan_go_d   = scan_go_q;
    scan_up_d   = scan_up_q;
    scan_low_d  = scan_low_q;
    rd_v_d      = 1'b0;
    rd_idx_d    = rd_idx_q;
    clr_d       = clr_q;
    clr_item_d  = clr_item_q;
    res_coef_d  = res_coef_q;
    res_idx_d   = res_idx_q;
    res_found_d = res_found_q;
    res_sat_d   = res_sat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_coef_d  = out_coef_q;
    out_eval_d  = out_eval_q;
    out_deg_d   = out_deg_q;
    out_idx_d   = out_idx_q;
    out_found_d = out_found_q;
    out_sat_d   = out_sat_q;
    mem_we      = 1'b0;
    mem_wa      = ex_q[AW-1:0];
    mem_wd      = wr_val;
    mem_ra      = ex_q[AW-1:0];

    case (state_q)
      pcs_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        deg_d  = '0;
        if (clr_q == LastIdx) begin
          state_d = clr_item_q ? pcs_pkg::S_DONE : pcs_pkg::S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      pcs_pkg::S_IDLE: begin
        mem_ra = (pcs_pkg::cmd_e'(cmd_i) == pcs_pkg::CMD_EVAL) ? deg_q : exponent_in_i[AW-1:0];
        if (in_valid_i) begin
          cmd_d       = pcs_pkg::cmd_e'(cmd_i);
          ex_d        = exponent_in_i;
          x_d         = value_in_i;
          acc_d       = '0;
          res_coef_d  = '0;
          res_idx_d   = '0;
          res_found_d = 1'b0;
          res_sat_d   = 1'b0;
          case (pcs_pkg::cmd_e'(cmd_i))
            pcs_pkg::CMD_ASSIGN, pcs_pkg::CMD_ADD, pcs_pkg::CMD_READ: begin
              state_d = pcs_pkg::S_ACCESS;
            end
            pcs_pkg::CMD_EVAL: begin
              state_d = pcs_pkg::S_EV_LOAD;
            end
            pcs_pkg::CMD_NEXT: begin
              scan_d     = nx_start6[AW-1:0];
              scan_end_d = LastIdx;
              scan_go_d  = nx_start6 < LiveW;
              scan_up_d  = 1'b1;
              scan_low_d = 1'b0;
              state_d    = pcs_pkg::S_SCAN;
            end
            pcs_pkg::CMD_PREV: begin
              scan_d     = pv_start6[AW-1:0];
              scan_end_d = '0;
              scan_go_d  = exponent_in_i != '0;
              scan_up_d  = 1'b0;
              scan_low_d = 1'b0;
              state_d    = pcs_pkg::S_SCAN;
            end
            pcs_pkg::CMD_CLEAR: begin
              clr_d      = '0;
              clr_item_d = 1'b1;
              deg_d      = '0;
              state_d    = pcs_pkg::S_CLEAR;
            end
            default: begin
              state_d = pcs_pkg::S_DONE;
            end
          endcase
        end
      end
      pcs_pkg::S_ACCESS: begin
        state_d = pcs_pkg::S_DONE;
        case (cmd_q)
          pcs_pkg::CMD_READ: begin
            if (in_range && ex_le_deg) begin
              res_coef_d = mem_rd_q;
            end
          end
          pcs_pkg::CMD_ASSIGN, pcs_pkg::CMD_ADD: begin
            if (in_range) begin
              mem_we     = 1'b1;
              res_coef_d = wr_val;
              res_sat_d  = (cmd_q == pcs_pkg::CMD_ADD) && add_res[CoefW];
              if (ex_gt_deg && (wr_val != '0)) begin
                deg_d = ex_q[AW-1:0];
              end else if (ex_eq_deg && (wr_val == '0) && (ex_q != '0)) begin
                scan_d     = ex_q[AW-1:0] - AW'(1);
                scan_end_d = '0;
                scan_go_d  = 1'b1;
                scan_up_d  = 1'b0;
                scan_low_d = 1'b1;
                state_d    = pcs_pkg::S_SCAN;
              end
            end
          end
          default: begin
            state_d = pcs_pkg::S_DONE;
          end
        endcase
      end
      pcs_pkg::S_EV_LOAD: begin
        acc_d = mem_rd_q;
        n_d   = deg_q;
        state_d = (deg_q == '0) ? pcs_pkg::S_DONE : pcs_pkg::S_EV_MUL;
      end
      pcs_pkg::S_EV_MUL: begin
        prod_d  = PW'(acc_q) * PW'(x_q);
        mem_ra  = n_q - AW'(1);
        n_d     = n_q - AW'(1);
        state_d = pcs_pkg::S_EV_ADD;
      end
      pcs_pkg::S_EV_ADD: begin
        acc_d     = ev_res[CoefW-1:0];
        res_sat_d = res_sat_q || ev_res[CoefW];
        state_d   = (n_q == '0) ? pcs_pkg::S_DONE : pcs_pkg::S_EV_MUL;
      end
      pcs_pkg::S_SCAN: begin
        mem_ra = scan_q;
        if (rd_hit) begin
          if (scan_low_q) begin
            deg_d = rd_idx_q;
          end else begin
            res_idx_d   = rd_idx_q;
            res_found_d = 1'b1;
          end
          state_d = pcs_pkg::S_DONE;
        end else if (scan_go_q) begin
          rd_v_d   = 1'b1;
          rd_idx_d = scan_q;
          if (scan_q == scan_end_q) begin
            scan_go_d = 1'b0;
          end else begin
            scan_d = scan_up_q ? scan_q + AW'(1) : scan_q - AW'(1);
          end
        end else if (!rd_v_q) begin
          if (scan_low_q) begin
            deg_d = '0;
          end
          state_d = pcs_pkg::S_DONE;
        end
      end
      pcs_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_coef_d  = DataW'(res_coef_q);
          out_eval_d  = DataW'(acc_q);
          out_deg_d   = ExpW'(deg_q);
          out_idx_d   = ExpW'(res_idx_q);
          out_found_d = res_found_q;
          out_sat_d   = res_sat_q;
          clr_item_d  = 1'b0;
          state_d     = pcs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pcs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcs_pkg::S_CLEAR;
      deg_q       <= '0;
      clr_q       <= '0;
      clr_item_q  <= 1'b0;
      scan_go_q   <= 1'b0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      deg_q       <= deg_d;
      clr_q       <= clr_d;
      clr_item_q  <= clr_item_d;
      scan_go_q   <= scan_go_d;
      rd_v_q      <= rd_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    ex_q        <= ex_d;
    x_q         <= x_d;
    acc_q       <= acc_d;
    prod_q      <= prod_d;
    n_q         <= n_d;
    scan_q      <= scan_d;
    scan_end_q  <= scan_end_d;
    scan_up_q   <= scan_up_d;
    scan_low_q  <= scan_low_d;
    rd_idx_q    <= rd_idx_d;
    res_coef_q  <= res_coef_d;
    res_idx_q   <= res_idx_d;
    res_found_q <= res_found_d;
    res_sat_q   <= res_sat_d;
    out_coef_q  <= out_coef_d;
    out_eval_q  <= out_eval_d;
    out_deg_q   <= out_deg_d;
    out_idx_q   <= out_idx_d;
    out_found_q <= out_found_d;
    out_sat_q   <= out_sat_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem[mem_ra];
  end

  assign in_stall_o   = state_q != pcs_pkg::S_IDLE;
  assign out_valid_o  = out_valid_q;
  assign coef_out_o   = out_coef_q;
  assign eval_out_o   = out_eval_q;
  assign degree_out_o = out_deg_q;
  assign term_index_o = out_idx_q;
  assign term_found_o = out_found_q;
  assign saturated_o  = out_sat_q;

  a_found_only_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && term_found_o |-> coef_out_o == '0 && eval_out_o == '0 && !saturated_o)
    else $error("search result carries arithmetic fields");

  a_deg_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ExpW + 1)'(deg_q) < LiveW)
    else $error("degree beyond table");

  a_clear_zero_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pcs_pkg::S_CLEAR |-> deg_q == '0)
    else $error("degree nonzero during clear");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != pcs_pkg::S_IDLE)
    else $error("sequencer idle after accepting a transaction");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == pcs_pkg::S_DONE))
    else $error("result raised outside done state");

endmodule

/* test/polynomial_coefficient_store_test.sv */
module polynomial_coefficient_store_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          Terms         = 32;
  localparam logic [2:0]  CmdUnused     = 3'd7;
  localparam longint      CoefMax       = 64'sd2147483647;
  localparam longint      CoefMin       = -CoefMax - 1;
  localparam int          StallLimit    = 2000;
  localparam int          SettleCycles  = 100;
  localparam logic [31:0] QOne          = 32'h0001_0000;
  localparam logic [31:0] QMax          = 32'h7fff_ffff;
  localparam logic [31:0] QMin          = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] coef;
    logic signed [31:0] value;
    logic [4:0]         degree;
    logic [4:0]         index;
    logic               found;
    logic               sat;
  } poly_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [2:0]         cmd_i         = '0;
  logic [4:0]         exponent_in_i = '0;
  logic signed [31:0] value_in_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic signed [31:0] coef_out_o;
  logic signed [31:0] eval_out_o;
  logic [4:0]         degree_out_o;
  logic [4:0]         term_index_o;
  logic               term_found_o;
  logic               saturated_o;

  logic signed [31:0] coef_model [Terms];
  logic [4:0]         degree_model;
  poly_result_t       awaited_results [$];
  poly_result_t       oldest_result;
  int                 error_count    = 0;
  int                 results_seen   = 0;
  int                 quiet_cycles   = 0;
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;

  polynomial_coefficient_store DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .exponent_in_i(exponent_in_i),
    .value_in_i   (value_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .coef_out_o   (coef_out_o),
    .eval_out_o   (eval_out_o),
    .degree_out_o (degree_out_o),
    .term_index_o (term_index_o),
    .term_found_o (term_found_o),
    .saturated_o  (saturated_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_model();
    foreach (coef_model[i]) coef_model[i] = '0;
    degree_model = '0;
  endfunction

  function automatic bit out_of_range(input longint x);
    return (x > CoefMax) || (x < CoefMin);
  endfunction

  function automatic longint saturate(input longint x);
    if (x > CoefMax) return CoefMax;
    if (x < CoefMin) return CoefMin;
    return x;
  endfunction

  // -1 when no nonzero term lies below exponent e
  function automatic int lower_nonzero(input int e);
    for (int n = e - 1; n >= 0; n--) begin
      if (coef_model[n] != 0) return n;
    end
    return -1;
  endfunction

  function automatic void store_coef(input logic [4:0] e, input logic signed [31:0] c);
    int p;
    coef_model[e] = c;
    if (e > degree_model && c != 0) begin
      degree_model = e;
    end else if (e == degree_model && c == 0) begin
      p = lower_nonzero(int'(e));
      degree_model = (p >= 0) ? 5'(p) : 5'd0;
    end
  endfunction

  function automatic poly_result_t apply_command(input logic [2:0] c, input logic [4:0] e,
                                                 input logic signed [31:0] v);
    poly_result_t r;
    longint       acc;
    int           n;
    r = '0;
    case (c)
      pcs_pkg::CMD_ASSIGN: begin
        r.coef = v;
        store_coef(e, v);
      end
      pcs_pkg::CMD_ADD: begin
        acc = longint'(coef_model[e]) + longint'(v);
        r.sat = out_of_range(acc);
        acc = saturate(acc);
        r.coef = acc[31:0];
        store_coef(e, r.coef);
      end
      pcs_pkg::CMD_READ: begin
        if (e <= degree_model) r.coef = coef_model[e];
      end
      pcs_pkg::CMD_EVAL: begin
        acc = longint'(coef_model[degree_model]);
        for (n = int'(degree_model) - 1; n >= 0; n--) begin
          acc = (acc * longint'(v)) / 65536 + longint'(coef_model[n]);
          if (out_of_range(acc)) r.sat = 1'b1;
          acc = saturate(acc);
        end
        r.value = acc[31:0];
      end
      pcs_pkg::CMD_NEXT: begin
        for (n = int'(e) + 1; n < Terms; n++) begin
          if (coef_model[n] != 0) begin
            r.index = n[4:0];
            r.found = 1'b1;
            break;
          end
        end
      end
      pcs_pkg::CMD_PREV: begin
        n = lower_nonzero(int'(e));
        if (n >= 0) begin
          r.index = n[4:0];
          r.found = 1'b1;
        end
      end
      pcs_pkg::CMD_CLEAR: clear_model();
      default: ;
    endcase
    r.degree = degree_model;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                results_seen, name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result transaction with nothing pending");
      end else begin
        oldest_result = awaited_results.pop_front();
        check_field("coef_out",   coef_out_o,   oldest_result.coef);
        check_field("eval_out",   eval_out_o,   oldest_result.value);
        check_field("degree_out", degree_out_o, oldest_result.degree);
        check_field("term_index", term_index_o, oldest_result.index);
        check_field("term_found", term_found_o, oldest_result.found);
        check_field("saturated",  saturated_o,  oldest_result.sat);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no transaction for %0d cycles", StallLimit);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [2:0] c, input logic [4:0] e, input logic [31:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    exponent_in_i <= e;
    value_in_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    awaited_results.push_back(apply_command(c, e, v));
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_store();
    send_item(pcs_pkg::CMD_READ, 5'd0, QMax);
    send_item(pcs_pkg::CMD_EVAL, 5'd0, QOne);
    send_item(pcs_pkg::CMD_NEXT, 5'd0, '0);
    send_item(pcs_pkg::CMD_PREV, 5'd31, '0);
    send_item(CmdUnused, 5'd31, QMin);
  endtask

  task automatic test_coefficient_updates();
    send_item(pcs_pkg::CMD_ASSIGN, 5'd31, QMax);
    send_item(pcs_pkg::CMD_ASSIGN, 5'd0, QMin);
    send_item(pcs_pkg::CMD_ASSIGN, 5'd5, QOne);
    send_item(pcs_pkg::CMD_READ, 5'd31, '0);
    send_item(pcs_pkg::CMD_ADD, 5'd31, QMax);
    send_item(pcs_pkg::CMD_ADD, 5'd0, 32'hffff_ffff);
  endtask

  task automatic test_evaluation();
    send_item(pcs_pkg::CMD_EVAL, 5'd0, QMax);
    send_item(pcs_pkg::CMD_EVAL, 5'd0, QMin);
    send_item(pcs_pkg::CMD_EVAL, 5'd0, QOne);
  endtask

  task automatic test_term_search();
    send_item(pcs_pkg::CMD_NEXT, 5'd5, '0);
    send_item(pcs_pkg::CMD_PREV, 5'd31, '0);
    send_item(pcs_pkg::CMD_NEXT, 5'd31, '0);
    send_item(pcs_pkg::CMD_PREV, 5'd0, '0);
  endtask

  task automatic test_degree_tracking();
    send_item(pcs_pkg::CMD_ASSIGN, 5'd31, '0);
    send_item(pcs_pkg::CMD_READ, 5'd31, '0);
    send_item(pcs_pkg::CMD_ASSIGN, 5'd5, '0);
    send_item(pcs_pkg::CMD_ASSIGN, 5'd0, '0);
  endtask

  task automatic test_unused_and_clear();
    send_item(pcs_pkg::CMD_ASSIGN, 5'd3, 32'hfffe_8000);
    send_item(CmdUnused, 5'd3, QMax);
    send_item(pcs_pkg::CMD_CLEAR, 5'd17, QMax);
    send_item(pcs_pkg::CMD_EVAL, 5'd0, QMin);
  endtask

  task automatic pick_random_item(output logic [2:0] c, output logic [4:0] e,
                                  output logic [31:0] v);
    int          roll;
    logic [17:0] narrow;
    logic [21:0] medium_val;
    roll = $urandom_range(99);
    if (roll < 26)      c = pcs_pkg::CMD_ASSIGN;
    else if (roll < 46) c = pcs_pkg::CMD_ADD;
    else if (roll < 60) c = pcs_pkg::CMD_READ;
    else if (roll < 75) c = pcs_pkg::CMD_EVAL;
    else if (roll < 86) c = pcs_pkg::CMD_NEXT;
    else if (roll < 97) c = pcs_pkg::CMD_PREV;
    else if (roll < 99) c = pcs_pkg::CMD_CLEAR;
    else                c = CmdUnused;
    e = ($urandom_range(3) == 0) ? degree_model : 5'($urandom_range(31));
    narrow = 18'($urandom);
    medium_val = 22'($urandom);
    roll = $urandom_range(99);
    if (c == pcs_pkg::CMD_EVAL) begin
      // keep x mostly within +-2.0 so high degrees do not always clip
      if (roll < 70)      v = {{14{narrow[17]}}, narrow};
      else if (roll < 85) v = $urandom;
      else if (roll < 90) v = QMax;
      else if (roll < 95) v = QMin;
      else                v = $urandom_range(1) ? QOne : -QOne;
    end else begin
      if (roll < 15)      v = '0;
      else if (roll < 25) v = $urandom_range(1) ? QMax : QMin;
      else if (roll < 65) v = {{10{medium_val[21]}}, medium_val};
      else                v = $urandom;
    end
  endtask

  task automatic test_random_traffic(input int count);
    logic [2:0]  c;
    logic [4:0]  e;
    logic [31:0] v;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_results_drained();
      pick_random_item(c, e, v);
      send_item(c, e, v);
    end
  endtask

  initial begin
    clear_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 8;
    recv_stall_pct = 65;
    test_empty_store();
    test_coefficient_updates();
    test_evaluation();
    test_term_search();
    test_degree_tracking();
    test_unused_and_clear();
    test_random_traffic(650);

    send_idle_pct  = 65;
    recv_stall_pct = 8;
    test_random_traffic(650);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(650);

    wait_results_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
